[hw/rtl/radial_mesh_derivative_top_defines.svh]
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
// Both macros expect clk and arst_n in the scope of use.
`ifndef RADIAL_MESH_DERIVATIVE_TOP_DEFINES_SVH
`define RADIAL_MESH_DERIVATIVE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked on every clock while out of reset
`define RMD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Condition followed in the next cycle by a consequence
`define RMD_ASSERT_NEXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("assertion failed");

`else

`define RMD_ASSERT(label, prop)
`define RMD_ASSERT_NEXT(label, cond, conseq)

`endif

`endif

[hw/rtl/rmd_pkg.sv]
`default_nettype none

package rmd_pkg;

	// Fixed field widths
	localparam int LOG_FRAC_BITS = 28;
	localparam int RADIUS_WIDTH  = 32;
	localparam int MESH_WIDTH    = 32;
	localparam int STEP_WIDTH    = 32;
	localparam int PROD_WIDTH    = MESH_WIDTH + RADIUS_WIDTH;
	// divisor carries a stencil weight of at most 12
	localparam int DEN_WIDTH     = PROD_WIDTH + 4;
	// numerator growth: weights sum to at most 18 in magnitude
	localparam int NUM_GUARD     = 5;

	// Points seen in the current run
	localparam int COUNT_WIDTH = 3;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	localparam count_t COUNT_STEP   = 3'd2;
	localparam count_t COUNT_PRIMED = 3'd3;
	localparam count_t COUNT_FULL   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_NUM,
		ST_DEN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_PUT,
		ST_TRAIL,
		ST_TRAIL_LAST,
		ST_ERR
	} ctrl_state_t;

	// Which stencil the current pass evaluates
	typedef enum logic [1:0] {
		JOB_POINT0,
		JOB_POINT1,
		JOB_INTERIOR
	} job_t;

	// What goes into the output register
	typedef enum logic [2:0] {
		PUT_NONE,
		PUT_QUOT,
		PUT_ZERO,
		PUT_ZERO_LAST,
		PUT_ERROR
	} put_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_PREP,
		DIV_ITER,
		DIV_FIN
	} div_state_t;

	// Sequencer to datapath
	typedef struct packed {
		logic in_ready;
		logic shift_win;
		logic set_step;
		logic count_inc;
		logic count_clr;
		logic count_full;
		logic load_num;
		logic load_den;
		logic div_start;
		put_t put;
		job_t job;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic   in_valid;
		logic   item_last;
		logic   out_free;
		logic   div_done;
		count_t count;
	} stat_t;

endpackage

`default_nettype wire

[hw/rtl/rmd_point_if.sv]
`default_nettype none

interface rmd_point_if #(parameter int VALUE_WIDTH = 32);
	import rmd_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] sample;
	logic [RADIUS_WIDTH-1:0]       radius;
	logic                          last_sample;

	modport source (output valid, sample, radius, last_sample, input ready);
	modport sink (input valid, sample, radius, last_sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/rmd_result_if.sv]
`default_nettype none

interface rmd_result_if #(parameter int VALUE_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] derivative;
	logic                          last_result;
	logic                          saturated;
	logic                          run_error;

	modport source (output valid, derivative, last_result, saturated, run_error, input ready);
	modport sink (input valid, derivative, last_result, saturated, run_error, output ready);
endinterface

`default_nettype wire

[hw/rtl/rmd_divider.sv]
`default_nettype none

// Shared restoring divider: trunc(|num| * 2^shift / den), signed and saturated.
// One quotient bit per cycle after a setup step that screens overflow.
module rmd_divider #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             start,
	input  wire logic signed [VALUE_WIDTH+rmd_pkg::NUM_GUARD-1:0] num,
	input  wire logic [rmd_pkg::DEN_WIDTH-1:0]                    den,
	input  wire logic                                             den_neg,
	input  wire logic                                             log_grid,
	output logic                                                  done,
	output logic signed [VALUE_WIDTH-1:0]                         quot,
	output logic                                                  sat
);
	import rmd_pkg::*;

	localparam int NW    = VALUE_WIDTH + NUM_GUARD;
	localparam int LOGSH = LOG_FRAC_BITS + FRACTION_BITS;
	localparam int DW    = NW + LOGSH;
	localparam int HIW   = DW - VALUE_WIDTH;
	localparam int CMPW  = (HIW > DEN_WIDTH) ? HIW : DEN_WIDTH;
	localparam int CW    = $clog2(VALUE_WIDTH);
	localparam logic [VALUE_WIDTH-1:0] HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	div_state_t               state_q, state_d;
	logic [DW-1:0]            d_q;
	logic [DEN_WIDTH-1:0]     den_q;
	logic [DEN_WIDTH-1:0]     rem_q;
	logic [VALUE_WIDTH-1:0]   quo_q;
	logic [CW-1:0]            cnt_q;
	logic                     neg_q, zero_den_q, mag_zero_q, over_q;
	logic                     done_q;
	logic [VALUE_WIDTH-1:0]   res_q, res_d;
	logic                     sat_q, sat_d;

	logic [NW-1:0]            mag;
	logic [CMPW-1:0]          hi_ext;
	logic                     hi_over;
	logic [DEN_WIDTH:0]       rem_sh, rem_diff;
	logic                     ge;
	logic                     lim_over;

	// Operand preparation and one restoring step
	always_comb begin
		mag      = num[NW-1] ? $unsigned(-num) : $unsigned(num);
		hi_ext   = CMPW'(d_q[DW-1:VALUE_WIDTH]);
		hi_over  = hi_ext >= CMPW'(den_q);
		rem_sh   = {rem_q, d_q[VALUE_WIDTH-1]};
		rem_diff = rem_sh - {1'b0, den_q};
		ge       = rem_sh >= {1'b0, den_q};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: if (start) state_d = DIV_PREP;
			DIV_PREP: state_d = (hi_over || zero_den_q) ? DIV_FIN : DIV_ITER;
			DIV_ITER: if (cnt_q == '0) state_d = DIV_FIN;
			DIV_FIN:  state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	// Final sign and saturation
	always_comb begin
		lim_over = neg_q ? (quo_q > HALF) : (quo_q >= HALF);
		if (zero_den_q) begin
			sat_d = 1'b1;
			res_d = mag_zero_q ? '0 : (neg_q ? HALF : ~HALF);
		end else if (over_q || lim_over) begin
			sat_d = 1'b1;
			res_d = neg_q ? HALF : ~HALF;
		end else begin
			sat_d = 1'b0;
			res_d = neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DIV_FIN);
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					d_q        <= log_grid ? (DW'(mag) << LOGSH) : (DW'(mag) << FRACTION_BITS);
					den_q      <= den;
					neg_q      <= num[NW-1] ^ den_neg;
					mag_zero_q <= (num == '0);
					zero_den_q <= (den == '0);
				end
			end
			DIV_PREP: begin
				over_q <= hi_over;
				rem_q  <= DEN_WIDTH'(hi_ext);
				quo_q  <= '0;
				cnt_q  <= CW'(VALUE_WIDTH - 1);
			end
			DIV_ITER: begin
				rem_q <= ge ? rem_diff[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
				d_q   <= d_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			DIV_FIN: begin
				res_q <= res_d;
				sat_q <= sat_d;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = $signed(res_q);
	assign sat  = sat_q;

endmodule

`default_nettype wire

[hw/rtl/rmd_ctrl.sv]
`default_nettype none

// Sequencer: one stencil result per numerator, divisor, divider pass.
module rmd_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rmd_pkg::stat_t  stat,
	output rmd_pkg::ctrl_t       ctrl
);
	import rmd_pkg::*;

	ctrl_state_t state_q, state_d;
	job_t        job_q, job_d;
	logic        primed;

	assign primed = (stat.count >= COUNT_PRIMED);

	// Next state and stencil selection
	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		case (state_q)
			ST_IDLE: if (stat.in_valid) state_d = ST_EVAL;
			ST_EVAL: begin
				if (!primed) begin
					state_d = stat.item_last ? ST_ERR : ST_IDLE;
				end else begin
					state_d = ST_NUM;
					job_d   = (stat.count == COUNT_PRIMED) ? JOB_POINT0 : JOB_INTERIOR;
				end
			end
			ST_NUM:      state_d = ST_DEN;
			ST_DEN:      state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (stat.div_done) state_d = ST_PUT;
			ST_PUT: begin
				if (stat.out_free) begin
					if (job_q == JOB_POINT0) begin
						state_d = ST_NUM;
						job_d   = JOB_POINT1;
					end else begin
						state_d = stat.item_last ? ST_TRAIL : ST_IDLE;
					end
				end
			end
			ST_TRAIL:      if (stat.out_free) state_d = ST_TRAIL_LAST;
			ST_TRAIL_LAST: if (stat.out_free) state_d = ST_IDLE;
			ST_ERR:        if (stat.out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Datapath strobes
	always_comb begin
		ctrl     = '0;
		ctrl.job = job_q;
		case (state_q)
			ST_IDLE: ctrl.in_ready = 1'b1;
			ST_EVAL: begin
				if (!primed && !stat.item_last) begin
					ctrl.shift_win = 1'b1;
					ctrl.count_inc = 1'b1;
					ctrl.set_step  = (stat.count == COUNT_STEP);
				end
			end
			ST_NUM:    ctrl.load_num  = 1'b1;
			ST_DEN:    ctrl.load_den  = 1'b1;
			ST_DIV_GO: ctrl.div_start = 1'b1;
			ST_PUT: begin
				if (stat.out_free) begin
					ctrl.put = PUT_QUOT;
					if (job_q != JOB_POINT0) begin
						ctrl.shift_win  = 1'b1;
						ctrl.count_full = !stat.item_last;
					end
				end
			end
			ST_TRAIL: if (stat.out_free) ctrl.put = PUT_ZERO;
			ST_TRAIL_LAST: begin
				if (stat.out_free) begin
					ctrl.put       = PUT_ZERO_LAST;
					ctrl.count_clr = 1'b1;
				end
			end
			ST_ERR: begin
				if (stat.out_free) begin
					ctrl.put       = PUT_ERROR;
					ctrl.count_clr = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= JOB_INTERIOR;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/radial_mesh_derivative_top.sv]
// Radial derivative of a sampled function on a linear or logarithmic mesh.
// point channel: one transaction per mesh point (sample, radius, last_sample);
//   a run ends at last_sample. result channel: one derivative per point,
//   in mesh order, with last_result on the run's final point; a run of under four points yields one error result.
// cfg_write_en / cfg_write_data write the mesh parameter (zero = linear grid);
//   write only while the block is idle.
// Throughput: one point is taken at a time; ready is low while it is worked.
//   A point that yields a stencil result is paced by the shared divider,
//   which produces one quotient bit per cycle.
//   The fourth point of a run needs two divider passes.
//   The first three points are only stored (the third also sets the step).
// Run end: the closing point adds two zero-valued results after its own.
// Reset: clears the run, the windows, the step and the mesh parameter.
// Stall: results sit in an output register; while it is full and not
//   taken the sequencer holds, and no further point is accepted.
`default_nettype none
`include "radial_mesh_derivative_top_defines.svh"

module radial_mesh_derivative_top #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write_en,
	input  wire logic [rmd_pkg::MESH_WIDTH-1:0] cfg_write_data,
	rmd_point_if.sink                           point,
	rmd_result_if.source                        result
);
	import rmd_pkg::*;

	localparam int NW = VALUE_WIDTH + NUM_GUARD;

	ctrl_t ctrl;
	stat_t stat;

	logic [MESH_WIDTH-1:0]         al_q;
	logic signed [VALUE_WIDTH-1:0] win_q [4];
	logic [RADIUS_WIDTH-1:0]       rad_q [3];
	logic [STEP_WIDTH-1:0]         step_q;
	count_t                        count_q;

	logic signed [VALUE_WIDTH-1:0] cur_s_q;
	logic [RADIUS_WIDTH-1:0]       cur_r_q;
	logic                          cur_last_q;

	logic signed [NW-1:0]          num_q, num_d;
	logic [PROD_WIDTH-1:0]         prod_q, prod_d;
	logic [DEN_WIDTH-1:0]          den_q, den_d, prod_ext;

	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] deriv_q;
	logic                          last_q, sat_q, err_q;

	logic                          accept, out_free, log_grid, den_neg;
	logic signed [NW-1:0]          f0, f1, f2, f3, f4;
	logic [RADIUS_WIDTH-1:0]       rsel;
	logic [STEP_WIDTH-1:0]         smag, step_d;
	logic signed [STEP_WIDTH:0]    step_diff;

	logic                          div_done, div_sat;
	logic signed [VALUE_WIDTH-1:0] div_quot;

	assign accept   = point.valid && point.ready;
	assign out_free = !out_valid_q || result.ready;
	assign log_grid = (al_q != '0);
	assign den_neg  = !log_grid && step_q[STEP_WIDTH-1];

	assign point.ready = ctrl.in_ready;

	assign stat.in_valid  = point.valid;
	assign stat.item_last = cur_last_q;
	assign stat.out_free  = out_free;
	assign stat.div_done  = div_done;
	assign stat.count     = count_q;

	rmd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	rmd_divider #(
		.VALUE_WIDTH   (VALUE_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.num      (num_q),
		.den      (den_q),
		.den_neg  (den_neg),
		.log_grid (log_grid),
		.done     (div_done),
		.quot     (div_quot),
		.sat      (div_sat)
	);

	// Stencil numerators from the sample window and the current sample
	always_comb begin
		f0 = NW'(win_q[0]);
		f1 = NW'(win_q[1]);
		f2 = NW'(win_q[2]);
		f3 = NW'(win_q[3]);
		f4 = NW'(cur_s_q);
		case (ctrl.job)
			JOB_POINT0:   num_d = (f2 <<< 2) - (f1 <<< 1) - f1 - f3;
			JOB_POINT1:   num_d = (f3 <<< 2) + (f3 <<< 1) - (f1 <<< 1) - (f2 <<< 1) - f2 - f4;
			JOB_INTERIOR: num_d = f0 - (f1 <<< 3) + (f3 <<< 3) - f4;
			default:      num_d = '0;
		endcase
	end

	// Grid scale: mesh parameter times radius, or the step magnitude
	always_comb begin
		rsel   = (ctrl.job == JOB_POINT0) ? rad_q[0] : rad_q[1];
		smag   = step_q[STEP_WIDTH-1] ? (~step_q + 1'b1) : step_q;
		prod_d = log_grid ? (al_q * rsel) : PROD_WIDTH'(smag);
	end

	// Stencil weight 2, 6 or 12 by shift and add
	always_comb begin
		prod_ext = DEN_WIDTH'(prod_q);
		case (ctrl.job)
			JOB_POINT0:   den_d = prod_ext << 1;
			JOB_POINT1:   den_d = (prod_ext << 2) + (prod_ext << 1);
			JOB_INTERIOR: den_d = (prod_ext << 3) + (prod_ext << 2);
			default:      den_d = '0;
		endcase
	end

	// Linear step r2 - r1, clamped to the signed step range
	always_comb begin
		step_diff = $signed({1'b0, cur_r_q}) - $signed({1'b0, rad_q[2]});
		if (step_diff[STEP_WIDTH] != step_diff[STEP_WIDTH-1]) begin
			step_d = step_diff[STEP_WIDTH] ? {1'b1, {(STEP_WIDTH-1){1'b0}}}
			                               : {1'b0, {(STEP_WIDTH-1){1'b1}}};
		end else begin
			step_d = step_diff[STEP_WIDTH-1:0];
		end
	end

	// Control state: mesh parameter, run count, output valid, current last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			al_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			cur_last_q  <= 1'b0;
		end else begin
			if (cfg_write_en) al_q <= cfg_write_data;
			if (accept) cur_last_q <= point.last_sample;
			if (ctrl.count_clr) begin
				count_q <= '0;
			end else if (ctrl.count_full) begin
				count_q <= COUNT_FULL;
			end else if (ctrl.count_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (ctrl.put != PUT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Windows and step, reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '{default: '0};
			rad_q  <= '{default: '0};
			step_q <= '0;
		end else begin
			if (ctrl.set_step) step_q <= step_d;
			if (ctrl.shift_win) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= cur_s_q;
				rad_q[0] <= rad_q[1];
				rad_q[1] <= rad_q[2];
				rad_q[2] <= cur_r_q;
			end
		end
	end

	// Current point and arithmetic operands
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s_q <= point.sample;
			cur_r_q <= point.radius;
		end
		if (ctrl.load_num) begin
			num_q  <= num_d;
			prod_q <= prod_d;
		end
		if (ctrl.load_den) den_q <= den_d;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		case (ctrl.put)
			PUT_QUOT: begin
				deriv_q <= div_quot;
				last_q  <= 1'b0;
				sat_q   <= div_sat;
				err_q   <= 1'b0;
			end
			PUT_ZERO: begin
				deriv_q <= '0;
				last_q  <= 1'b0;
				sat_q   <= 1'b0;
				err_q   <= 1'b0;
			end
			PUT_ZERO_LAST: begin
				deriv_q <= '0;
				last_q  <= 1'b1;
				sat_q   <= 1'b0;
				err_q   <= 1'b0;
			end
			PUT_ERROR: begin
				deriv_q <= '0;
				last_q  <= 1'b1;
				sat_q   <= 1'b0;
				err_q   <= 1'b1;
			end
			default: ;
		endcase
	end

	assign result.valid       = out_valid_q;
	assign result.derivative  = deriv_q;
	assign result.last_result = last_q;
	assign result.saturated   = sat_q;
	assign result.run_error   = err_q;

	// Checks
	`RMD_ASSERT(a_count_range, count_q <= COUNT_FULL)
	`RMD_ASSERT(a_put_when_free, (ctrl.put != PUT_NONE) |-> (!out_valid_q || result.ready))
	`RMD_ASSERT_NEXT(a_busy_after_accept, point.valid && point.ready, !point.ready)
	`RMD_ASSERT(a_error_shape, (result.valid && result.run_error) |-> (result.last_result && !result.saturated && result.derivative == '0))

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import rmd_pkg::*;

	localparam int FRACTION_BITS = 16;
	// idle time after the last result before a register write or the end
	localparam int SETTLE_CYCLES = 100;
	// long receiver hold-off used to back up the block
	localparam int HOLD_CYCLES   = 400;
	// cycles with no transaction on either channel before giving up
	localparam int STUCK_LIMIT   = 2000;

	typedef struct packed {
		logic signed [31:0] derivative;
		logic               last_result;
		logic               saturated;
		logic               run_error;
	} deriv_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write_en;
	logic [MESH_WIDTH-1:0] cfg_write_data;

	rmd_point_if  #(.VALUE_WIDTH(32)) point_ch ();
	rmd_result_if #(.VALUE_WIDTH(32)) result_ch ();

	radial_mesh_derivative_top #(
		.VALUE_WIDTH(32),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.point(point_ch),
		.result(result_ch)
	);

	// Mirror of the block state
	logic [31:0]        mesh_param = '0;
	logic signed [31:0] f_win [4] = '{default: '0};
	logic [31:0]        r_win [3] = '{default: '0};
	logic [31:0]        grid_step = '0;
	int                 run_points = 0;

	deriv_result_t pending_derivs [$];
	int            mismatch_count = 0;
	int            stuck_cycles = 0;
	bit            quiet = 1'b0;
	bit            hold_now = 1'b0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Truncated, saturated quotient of num * 2^shift by a signed divisor
	function automatic deriv_result_t quotient_of(input longint num, input logic den_neg,
			input logic [127:0] den, input int shift);
		deriv_result_t res;
		logic          neg;
		logic [127:0]  mag;
		logic [127:0]  quo;
		logic [127:0]  lim;
		res = '0;
		neg = (num < 0) ^ den_neg;
		mag = (num < 0) ? 128'(-num) : 128'(num);
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (den == '0) begin
			res.saturated = 1'b1;
			if (mag != '0)
				res.derivative = lim[31:0];
			return res;
		end
		quo = (mag << shift) / den;
		if (quo > lim) begin
			res.saturated = 1'b1;
			quo = lim;
		end
		res.derivative = neg ? -quo[31:0] : quo[31:0];
		return res;
	endfunction

	// Divisor is weight * step on a linear grid, weight * al * r on a log grid
	function automatic deriv_result_t point_derivative(input longint num, input int weight,
			input logic [31:0] rad);
		logic [31:0]  step_mag;
		logic [127:0] den;
		if (mesh_param == '0) begin
			step_mag = grid_step[31] ? -grid_step : grid_step;
			den = 128'(step_mag) * 128'(weight);
			return quotient_of(num, grid_step[31], den, FRACTION_BITS);
		end
		den = 128'(mesh_param) * 128'(rad) * 128'(weight);
		return quotient_of(num, 1'b0, den, LOG_FRAC_BITS + FRACTION_BITS);
	endfunction

	function automatic void shift_window(input logic signed [31:0] s, input logic [31:0] r);
		f_win[0] = f_win[1];
		f_win[1] = f_win[2];
		f_win[2] = f_win[3];
		f_win[3] = s;
		r_win[0] = r_win[1];
		r_win[1] = r_win[2];
		r_win[2] = r;
	endfunction

	// Queue the derivatives that one accepted mesh point releases
	function automatic void predict_point(input logic signed [31:0] s, input logic [31:0] r,
			input logic last);
		deriv_result_t d;
		logic [31:0]   diff;
		longint        fv [5];
		d = '0;
		if (run_points < 3) begin
			// short run: one error result, then a fresh run
			if (last) begin
				d.last_result = 1'b1;
				d.run_error = 1'b1;
				pending_derivs.push_back(d);
				run_points = 0;
				return;
			end
			// third point fixes the linear step, clamped to 32 signed bits
			if (run_points == 2) begin
				if (r >= r_win[2]) begin
					diff = r - r_win[2];
					grid_step = (diff > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : diff;
				end else begin
					diff = r_win[2] - r;
					grid_step = (diff > 32'h8000_0000) ? 32'h8000_0000 : -diff;
				end
			end
			shift_window(s, r);
			run_points++;
			return;
		end
		for (int j = 0; j < 4; j++)
			fv[j] = longint'(f_win[j]);
		fv[4] = longint'(s);
		if (run_points == 3) begin
			// one-sided formulas for the first two points
			pending_derivs.push_back(point_derivative(-3 * fv[1] + 4 * fv[2] - fv[3], 2,
				r_win[0]));
			pending_derivs.push_back(point_derivative(-2 * fv[1] - 3 * fv[2] + 6 * fv[3]
				- fv[4], 6, r_win[1]));
		end else begin
			pending_derivs.push_back(point_derivative(fv[0] - 8 * fv[1] + 8 * fv[3] - fv[4],
				12, r_win[1]));
		end
		shift_window(s, r);
		if (last) begin
			// two trailing zero results close the run
			pending_derivs.push_back(d);
			d.last_result = 1'b1;
			pending_derivs.push_back(d);
			run_points = 0;
		end else begin
			run_points = 4;
		end
	endfunction

	// One point transaction; valid stays high for a back-to-back follow-up
	task automatic send_point(input logic signed [31:0] s, input logic [31:0] r,
			input logic last);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			point_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		point_ch.valid <= 1'b1;
		point_ch.sample <= s;
		point_ch.radius <= r;
		point_ch.last_sample <= last;
		do @(negedge clk); while (!point_ch.ready);
		predict_point(s, r, last);
		@(posedge clk);
	endtask

	// Stop offering points and let the block drain completely
	task automatic settle_block();
		point_ch.valid <= 1'b0;
		while (pending_derivs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mesh_param(input logic [31:0] value);
		settle_block();
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		mesh_param = value;
	endtask

	// mode 0: smooth grid and small samples; 1: full-range samples; 2: all full range
	task automatic send_random_run(input int len, input int mode);
		logic [31:0]        base;
		logic [31:0]        stride;
		logic signed [31:0] s;
		logic [31:0]        r;
		bit                 down;
		int                 i;
		base = $urandom_range(32'h0020_0000, 32'h0100_0000);
		stride = $urandom_range(32'h0000_0400, 32'h0002_0000);
		down = $urandom_range(0, 1);
		for (i = 0; i < len; i++) begin
			if (mode == 0)
				s = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			else
				s = $urandom;
			if (mode == 2)
				r = $urandom;
			else
				r = down ? base - i * stride : base + i * stride;
			send_point(s, r, i == len - 1);
		end
	endtask

	task automatic test_linear_grid_edges();
		write_mesh_param(32'h0000_0000);
		// descending grid: negative step
		send_point(32'sh0001_0000, 32'h0004_0000, 1'b0);
		send_point(32'sh0004_0000, 32'h0003_0000, 1'b0);
		send_point(32'sh0009_0000, 32'h0002_0000, 1'b0);
		send_point(32'sh0010_0000, 32'h0001_0000, 1'b1);
		// full-scale samples, step clamped to the positive limit
		send_point(32'sh7FFF_FFFF, 32'h0000_0000, 1'b0);
		send_point(32'sh8000_0000, 32'h0000_0000, 1'b0);
		send_point(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_point(32'sh8000_0000, 32'h0000_0001, 1'b1);
		// step clamped to the negative limit
		send_point(32'sh0000_0001, 32'hFFFF_FFFF, 1'b0);
		send_point(-32'sh0000_0001, 32'hFFFF_FFFF, 1'b0);
		send_point(32'sh0001_2345, 32'h0000_0000, 1'b0);
		send_point(-32'sh0005_4321, 32'h0000_0002, 1'b1);
		// zero step: divide by zero with zero and negative numerators
		send_point(32'sh0000_0007, 32'h0000_0003, 1'b0);
		send_point(32'sh0000_0007, 32'h0000_0003, 1'b0);
		send_point(32'sh0000_0007, 32'h0000_0003, 1'b0);
		send_point(32'sh0000_0009, 32'h0000_0003, 1'b1);
	endtask

	// Runs of one, two and three points end in an error result
	task automatic test_short_runs();
		send_point(32'sh0000_1000, 32'h0001_0000, 1'b1);
		send_point(32'sh0000_2000, 32'h0001_0000, 1'b0);
		send_point(32'sh0000_3000, 32'h0002_0000, 1'b1);
		send_point(32'sh0000_4000, 32'h0001_0000, 1'b0);
		send_point(32'sh0000_5000, 32'h0002_0000, 1'b0);
		send_point(32'sh0000_6000, 32'h0003_0000, 1'b1);
	endtask

	// Tiny log spacing overflows to the negative limit; a zero radius divides by zero
	task automatic test_log_grid_overflow();
		write_mesh_param(32'h0000_0001);
		send_point(32'sh7FFF_FFFF, 32'h0000_0001, 1'b0);
		send_point(32'sh8000_0000, 32'h0000_0000, 1'b0);
		send_point(32'sh7FFF_FFFF, 32'h0000_0001, 1'b0);
		send_point(32'sh8000_0000, 32'h0000_0001, 1'b1);
	endtask

	task automatic test_random_phase(input logic [31:0] param, input int n_items);
		int sent;
		int len;
		int mode;
		write_mesh_param(param);
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			mode = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
			send_random_run(len, mode);
			sent += len;
		end
	endtask

	// Receiver holds off while points keep coming, so the input stalls
	task automatic test_result_backpressure();
		hold_now = 1'b1;
		send_random_run(10, 0);
	endtask

	// Result receiver: random stalls, one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_now) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_now = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Check each result transaction against the oldest expectation
	always @(negedge clk) begin : check_results
		deriv_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_derivs.size() == 0) begin
				$error("unexpected result: derivative %h last %b sat %b err %b",
					result_ch.derivative, result_ch.last_result, result_ch.saturated,
					result_ch.run_error);
				mismatch_count++;
			end else begin
				want = pending_derivs.pop_front();
				if (result_ch.derivative !== want.derivative) begin
					$error("derivative: expected %h, got %h", want.derivative,
						result_ch.derivative);
					mismatch_count++;
				end
				if (result_ch.last_result !== want.last_result) begin
					$error("last_result: expected %b, got %b", want.last_result,
						result_ch.last_result);
					mismatch_count++;
				end
				if (result_ch.saturated !== want.saturated) begin
					$error("saturated: expected %b, got %b", want.saturated,
						result_ch.saturated);
					mismatch_count++;
				end
				if (result_ch.run_error !== want.run_error) begin
					$error("run_error: expected %b, got %b", want.run_error,
						result_ch.run_error);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: no transaction on either channel for too long
	always @(negedge clk) begin
		if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Test sequence
	initial begin
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_write_data <= '0;
		point_ch.valid <= 1'b0;
		point_ch.sample <= '0;
		point_ch.radius <= '0;
		point_ch.last_sample <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_linear_grid_edges();
		test_short_runs();
		test_log_grid_overflow();
		test_random_phase(32'h0000_0000, 20);
		test_random_phase($urandom_range(32'h0004_0000, 32'h0400_0000), 20);
		test_random_phase($urandom, 20);
		test_random_phase(32'hFFFF_FFFF, 15);
		test_result_backpressure();
		quiet = 1'b1;
		test_random_phase($urandom_range(32'h0004_0000, 32'h0400_0000), 30);

		settle_block();
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/rmd_pkg.sv
hw/rtl/rmd_point_if.sv
hw/rtl/rmd_result_if.sv
hw/rtl/rmd_divider.sv
hw/rtl/rmd_ctrl.sv
hw/rtl/radial_mesh_derivative_top.sv
tb/sv/testbench.sv
